// ----- rtl/core/lobt_pkg.sv -----
// Shared types, constants and command bundle for the order book table.
`timescale 1ns / 1ps
package lobt_pkg;

	localparam int MAX_ORDERS = 64;
	localparam int IDX_W      = $clog2(MAX_ORDERS);
	localparam int CNT_W      = IDX_W + 1;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_CANCEL = 3'd1,
		OP_PEEK   = 3'd2,
		OP_POP    = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_DUP       = 2'd3;

	// One table slot as held in the entry memory.
	typedef struct packed {
		logic [63:0] stamp;
		logic [31:0] qty;
		logic [31:0] id;
		logic [31:0] price;
		logic        buy;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             start;
		logic             issue;
		logic             eval;
		logic             phase2;
		logic             apply;
		logic             load;
		logic [IDX_W-1:0] addr;
	} cmd_t;

endpackage

// ----- rtl/core/lobt_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lobt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/lobt_dp.sv -----
// Datapath: entry memory, valid bits, scan accumulators and result register.
`timescale 1ns / 1ps
module lobt_dp import lobt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic [2:0]    in_op,
	input  logic [31:0]   in_id,
	input  logic          in_buy,
	input  logic [31:0]   in_price,
	input  logic [31:0]   in_qty,
	output logic [1:0]    res_status,
	output logic [167:0]  res_data
);

	logic [MAX_ORDERS-1:0] valid_q;
	logic [63:0]           counter_q;

	logic [2:0]  op_q;
	logic [31:0] id_q;
	logic        buy_q;
	logic [31:0] price_q;
	logic [31:0] qty_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           ent_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_slot_q;
	entry_t           hit_ent_q;
	logic             free_q;
	logic [IDX_W-1:0] free_slot_q;

	logic        bid_v_q, ask_v_q;
	logic [31:0] bid_q, ask_q;

	logic [1:0]  st_q;
	logic [31:0] f_id_q, f_price_q, f_qty_q;
	logic        f_buy_q;

	logic        is_ins, is_cancel, is_front, ins_ok;
	logic        match_id, match_lvl;
	logic        ram_we;
	entry_t      wr_ent;

	always_comb begin
		is_ins    = (op_q == OP_INSERT);
		is_cancel = (op_q == OP_CANCEL);
		is_front  = (op_q == OP_PEEK) || (op_q == OP_POP);
		match_id  = vld_s1 && (ent_s1.id == id_q);
		match_lvl = vld_s1 && (ent_s1.buy == buy_q) && (ent_s1.price == price_q);
		ins_ok    = is_ins && !hit_q && free_q;
		ram_we    = cmd.apply && ins_ok;
		wr_ent    = '{stamp: counter_q, qty: qty_q, id: id_q, price: price_q, buy: buy_q};
	end

	lobt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ORDERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_slot_q),
		.wdata (wr_ent),
		.re    (cmd.issue),
		.raddr (cmd.addr),
		.rdata (ent_s1)
	);

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			vld_s1 <= valid_q[cmd.addr];
			idx_s1 <= cmd.addr;
		end
		if (cmd.start) begin
			op_q    <= in_op;
			id_q    <= in_id;
			buy_q   <= in_buy;
			price_q <= in_price;
			qty_q   <= in_qty;
		end
		if (cmd.eval && !cmd.phase2) begin
			if ((is_ins || is_cancel) && match_id && !hit_q) begin
				hit_slot_q <= idx_s1;
				hit_ent_q  <= ent_s1;
			end else if (is_front && match_lvl &&
			             (!hit_q || ent_s1.stamp < hit_ent_q.stamp)) begin
				hit_slot_q <= idx_s1;
				hit_ent_q  <= ent_s1;
			end
			if (!vld_s1 && !free_q) begin
				free_slot_q <= idx_s1;
			end
		end
		if (cmd.eval && cmd.phase2 && vld_s1) begin
			if (ent_s1.buy) begin
				if (!bid_v_q || ent_s1.price > bid_q) begin
					bid_q <= ent_s1.price;
				end
			end else begin
				if (!ask_v_q || ent_s1.price < ask_q) begin
					ask_q <= ent_s1.price;
				end
			end
		end
		if (cmd.apply) begin
			if ((is_cancel || is_front) && hit_q) begin
				f_id_q    <= hit_ent_q.id;
				f_buy_q   <= hit_ent_q.buy;
				f_price_q <= hit_ent_q.price;
				f_qty_q   <= hit_ent_q.qty;
			end else begin
				f_id_q    <= '0;
				f_buy_q   <= 1'b0;
				f_price_q <= '0;
				f_qty_q   <= '0;
			end
			if (is_ins) begin
				st_q <= hit_q ? ST_DUP : (free_q ? ST_OK : ST_FULL);
			end else if ((is_cancel || is_front) && !hit_q) begin
				st_q <= ST_NOT_FOUND;
			end else begin
				st_q <= ST_OK;
			end
		end
		if (cmd.load) begin
			res_status <= st_q;
			res_data   <= {4'd0, !bid_v_q && !ask_v_q, ask_v_q ? ask_q : 32'd0, ask_v_q,
			               bid_v_q ? bid_q : 32'd0, bid_v_q, f_qty_q, f_price_q,
			               f_buy_q, f_id_q};
		end
	end

	// Control flags of the scans, the valid bits and the arrival counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			counter_q <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			bid_v_q   <= 1'b0;
			ask_v_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.eval && !cmd.phase2) begin
				if ((is_ins || is_cancel) && match_id) begin
					hit_q <= 1'b1;
				end else if (is_front && match_lvl) begin
					hit_q <= 1'b1;
				end
				if (!vld_s1) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.apply) begin
				bid_v_q <= 1'b0;
				ask_v_q <= 1'b0;
				if (ins_ok) begin
					valid_q[free_slot_q] <= 1'b1;
					counter_q            <= counter_q + 64'd1;
				end
				if (hit_q && (is_cancel || (op_q == OP_POP))) begin
					valid_q[hit_slot_q] <= 1'b0;
				end
			end else if (cmd.eval && cmd.phase2 && vld_s1) begin
				if (ent_s1.buy) begin
					bid_v_q <= 1'b1;
				end else begin
					ask_v_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/lobt_ctrl.sv -----
// Controller: request handshake, scan sequencing and result handshake.
`timescale 1ns / 1ps
module lobt_ctrl import lobt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN1 = 5'b00010,
		S_APPLY = 5'b00100,
		S_SCAN2 = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             eval_q;
	logic             out_valid_q;
	logic             scanning, scan_end, can_load;

	always_comb begin
		scanning   = (state_q == S_SCAN1) || (state_q == S_SCAN2);
		scan_end   = (cnt_q == CNT_W'(MAX_ORDERS));
		can_load   = !out_valid_q || out_ready;
		in_ready   = (state_q == S_IDLE);
		out_valid  = out_valid_q;
		cmd.start  = in_ready && in_valid;
		cmd.issue  = scanning && !scan_end;
		cmd.eval   = eval_q;
		cmd.phase2 = (state_q == S_SCAN2);
		cmd.apply  = (state_q == S_APPLY);
		cmd.load   = (state_q == S_DONE) && can_load;
		cmd.addr   = cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			eval_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			eval_q <= cmd.issue;
			if (cmd.issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= S_SCAN1;
					end
				end
				S_SCAN1: begin
					if (scan_end) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					cnt_q   <= '0;
					state_q <= S_SCAN2;
				end
				S_SCAN2: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/limit_order_book_table.sv -----
// Top level of the limit order book table with price-time priority.
`timescale 1ns / 1ps
// The block keeps up to MAX_ORDERS resting orders and applies one request at
// a time. A request arrives on the slave channel: s_tuser carries the
// operation (insert, cancel by id, peek or pop the oldest order of a level,
// query) and s_tdata the order id, side, price and quantity. Each request
// gives exactly one result on the master channel: m_tuser carries the
// status and m_tdata the order found and the book summary after the request.
// Each request takes two passes over the entry memory, one slot per cycle
// through its single read port: a search pass for the id, a free slot and
// the level front, then after the table update a pass for best bid and ask.
// The controller returns to idle at the clock edge that loads the result, and
// takes no new request before then. The result sits in an output register,
// so a new request may be accepted while the previous result still waits;
// if the receiver stalls, the finished request holds until the register is
// free. Reset clears all valid bits and the arrival counter at once, so the
// book is empty and s_tready is high from the first cycle after reset.
module limit_order_book_table import lobt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// order_id[31:0], buy_side[32], limit_price[64:33], quantity[96:65], zero pad
	input  logic [103:0] s_tdata,
	// op[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found_id[31:0], found_buy[32], found_price[64:33], found_qty[96:65],
	// bid_valid[97], bid_price[129:98], ask_valid[130], ask_price[162:131],
	// book_empty[163], zero pad
	output logic [167:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser
);

	cmd_t cmd;

	lobt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	lobt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_op      (s_tuser),
		.in_id      (s_tdata[31:0]),
		.in_buy     (s_tdata[32]),
		.in_price   (s_tdata[64:33]),
		.in_qty     (s_tdata[96:65]),
		.res_status (m_tuser),
		.res_data   (m_tdata)
	);

endmodule

// ----- sim/tb_limit_order_book_table.sv -----
// Self-checking testbench for the limit order book table.
`timescale 1ns / 1ps

// Keeps its own copy of the book and a queue of the results it expects.
class book_scoreboard;
	bit          live[64];
	bit          side[64];
	bit [31:0]   px[64];
	bit [31:0]   oid[64];
	bit [31:0]   amt[64];
	bit [63:0]   seq[64];
	bit [63:0]   arrivals;
	bit [167:0]  want_data[$];
	bit [1:0]    want_status[$];
	int          errors;
	int          checked;

	function int slot_of_id(bit [31:0] id);
		for (int i = 0; i < 64; i++)
			if (live[i] && oid[i] == id)
				return i;
		return -1;
	endfunction

	function int level_front(bit b, bit [31:0] p);
		int best;
		best = -1;
		for (int i = 0; i < 64; i++)
			if (live[i] && side[i] == b && px[i] == p)
				if (best < 0 || seq[i] < seq[best])
					best = i;
		return best;
	endfunction

	// Applies one accepted request to the book and queues the outcome.
	function void note_request(lobt_pkg::op_t op, bit [31:0] id, bit b,
			bit [31:0] p, bit [31:0] q);
		bit [1:0]   st;
		int         hit;
		int         fr;
		bit         hb;
		bit         ha;
		bit [31:0]  bid;
		bit [31:0]  ask;
		bit [167:0] d;
		st = lobt_pkg::ST_OK;
		hit = -1;
		hb = 0;
		ha = 0;
		bid = 0;
		ask = 0;
		d = '0;
		if (op == lobt_pkg::OP_INSERT) begin
			if (slot_of_id(id) >= 0) begin
				st = lobt_pkg::ST_DUP;
			end else begin
				fr = -1;
				for (int i = 63; i >= 0; i--)
					if (!live[i])
						fr = i;
				if (fr < 0) begin
					st = lobt_pkg::ST_FULL;
				end else begin
					live[fr] = 1;
					side[fr] = b;
					px[fr] = p;
					oid[fr] = id;
					amt[fr] = q;
					seq[fr] = arrivals;
					arrivals++;
				end
			end
		end else if (op == lobt_pkg::OP_CANCEL || op == lobt_pkg::OP_PEEK ||
				op == lobt_pkg::OP_POP) begin
			hit = (op == lobt_pkg::OP_CANCEL) ? slot_of_id(id) : level_front(b, p);
			if (hit < 0)
				st = lobt_pkg::ST_NOT_FOUND;
		end
		if (hit >= 0) begin
			d[31:0] = oid[hit];
			d[32] = side[hit];
			d[64:33] = px[hit];
			d[96:65] = amt[hit];
			if (op != lobt_pkg::OP_PEEK)
				live[hit] = 0;
		end
		for (int i = 0; i < 64; i++) begin
			if (live[i]) begin
				if (side[i]) begin
					if (!hb || px[i] > bid)
						bid = px[i];
					hb = 1;
				end else begin
					if (!ha || px[i] < ask)
						ask = px[i];
					ha = 1;
				end
			end
		end
		d[97] = hb;
		d[129:98] = bid;
		d[130] = ha;
		d[162:131] = ask;
		d[163] = !hb && !ha;
		want_data = {want_data, d};
		want_status = {want_status, st};
	endfunction

	function void check_result(bit [167:0] d, bit [1:0] st);
		bit [167:0] e;
		bit [1:0]   es;
		if (want_data.size() == 0) begin
			$display("%0t: unexpected result, status %0d data %h", $time, st, d);
			errors++;
			return;
		end
		e = want_data[0];
		want_data.delete(0);
		es = want_status[0];
		want_status.delete(0);
		checked++;
		if (st !== es) begin
			$display("%0t: status expected %0d actual %0d", $time, es, st);
			errors++;
		end
		if (d !== e) begin
			$display("%0t: data expected %h actual %h", $time, e, d);
			errors++;
		end
	endfunction
endclass

module tb_limit_order_book_table;
	import lobt_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [167:0] m_tdata;
	logic [1:0]   m_tuser;

	book_scoreboard book;
	longint         cycles;
	int             sent;
	bit [31:0]      used_ids[$];

	limit_order_book_table DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// The receiver stalls in its own rhythm: calm stretches, then noisy ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ((cycles / 3000) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Results are sampled at the edge where the handshake completes.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it. The valid
	// line stays high afterwards; the caller drops it before any gap.
	task automatic send_request(logic [2:0] op, bit [31:0] id, bit b, bit [31:0] p,
			bit [31:0] q);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, q, p, b, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		book.note_request(op_t'(op), id, b, p, q);
		if (id != 0)
			used_ids = {used_ids, id};
		sent++;
	endtask

	task automatic idle_cycles(int n);
		s_tvalid <= 1'b0;
		for (int i = 0; i < n; i++)
			@(posedge clk);
	endtask

	// Holds the sender back until every expected result has arrived.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (book.want_data.size() != 0)
			@(posedge clk);
	endtask

	function automatic bit [31:0] pick_id();
		if (used_ids.size() > 0 && $urandom_range(0, 1))
			return used_ids[$urandom_range(0, used_ids.size() - 1)];
		return $urandom_range(1, 200);
	endfunction

	function automatic bit [31:0] pick_price();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom_range(100, 107);
		endcase
	endfunction

	initial begin
		int          burst;
		logic [2:0]  op;
		int          opsel;
		book = new();
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty book, extremes, all operations, duplicate id,
		// time priority at one level and unused opcodes.
		send_request(OP_QUERY, 0, 0, 0, 0);
		send_request(OP_POP, 0, 1, 5, 0);
		send_request(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 0);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 0, 0, 0, 0);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 0, 7, 7);
		send_request(OP_INSERT, 10, 1, 50, 1);
		send_request(OP_INSERT, 11, 1, 50, 2);
		send_request(OP_PEEK, 0, 1, 50, 0);
		send_request(OP_POP, 0, 1, 50, 0);
		send_request(OP_PEEK, 0, 1, 50, 0);
		send_request(OP_CANCEL, 11, 0, 0, 0);
		send_request(OP_CANCEL, 11, 0, 0, 0);
		send_request(3'd5, 1, 1, 1, 1);
		send_request(3'd7, 1, 1, 1, 1);
		send_request(OP_CANCEL, 0, 0, 0, 0);
		send_request(OP_CANCEL, 32'hFFFF_FFFF, 0, 0, 0);

		// Fill the table to the brim, one more for the full status, then a duplicate id.
		for (int i = 0; i < 65; i++)
			send_request(OP_INSERT, 1000 + i, 1'(i % 2), 200 + i % 5, $urandom);
		send_request(OP_INSERT, 1000, 1, 1, 1);
		wait_drained();
		for (int i = 0; i < 64; i++)
			send_request((i % 2) ? OP_POP : OP_CANCEL, 1000 + i, 1'(i % 2),
				200 + i % 5, 0);

		// Random bursts; the mix leans on inserts so the book stays well stocked.
		while (sent < 1750) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst; k++) begin
				opsel = $urandom_range(0, 99);
				if (opsel < 40)
					op = OP_INSERT;
				else if (opsel < 58)
					op = OP_CANCEL;
				else if (opsel < 73)
					op = OP_PEEK;
				else if (opsel < 93)
					op = OP_POP;
				else if (opsel < 97)
					op = OP_QUERY;
				else
					op = 3'($urandom_range(5, 7));
				send_request(op, pick_id(), 1'($urandom_range(0, 1)), pick_price(),
					$urandom);
			end
			if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 300));
			if ($urandom_range(0, 40) == 0)
				wait_drained();
		end

		wait_drained();
		idle_cycles(2 * MAX_ORDERS + 10);
		$display("Sent %0d requests, checked %0d results, covering full table,",
			sent, book.checked);
		$display("duplicate ids, level priority, stalls and unused opcodes.");
		if (book.errors == 0 && book.want_data.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/lobt_pkg.sv
rtl/core/lobt_ram.sv
rtl/core/lobt_dp.sv
rtl/core/lobt_ctrl.sv
rtl/core/limit_order_book_table.sv
sim/tb_limit_order_book_table.sv
